/* rtl/glyph_bitmap_color_expand_unit_assert.svh */
// Assertion macros for the glyph bitmap color expansion unit.
`ifndef GLYPH_BITMAP_COLOR_EXPAND_UNIT_ASSERT_SVH
`define GLYPH_BITMAP_COLOR_EXPAND_UNIT_ASSERT_SVH

// Same-cycle implication.
`define GBCE_ASSERT_IMP(lbl, clk_s, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GBCE_ASSERT_NXT(lbl, clk_s, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/gbce_pkg.sv */
// Shared types and constants for the glyph bitmap color expansion unit.
package gbce_pkg;

  localparam int BYTE_W      = 8;
  localparam int CNT_W       = $clog2(BYTE_W);
  localparam int COLOR_W     = 16;
  localparam int SIDE_W      = 8;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_SIDE_DEFAULT = 128;

  localparam logic [COLOR_W-1:0] FG_RESET     = 16'hFFFF;
  localparam logic [COLOR_W-1:0] BG_RESET     = 16'h0000;
  localparam logic [SIDE_W-1:0]  WIDTH_RESET  = 8'd8;
  localparam logic [SIDE_W-1:0]  HEIGHT_RESET = 8'd16;

  typedef enum logic [1:0] {
    REG_FG     = 2'd0,
    REG_BG     = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_idx_t;

  // One bitmap byte after classification by the front end.
  typedef struct packed {
    logic [BYTE_W-1:0] byte_bits;
    logic [CNT_W-1:0]  cnt_m1;     // pixels to emit minus one
    logic              row_done;   // final pixel closes the glyph row
    logic              last_row;   // byte belongs to the glyph's last row
  } cmd_t;

  typedef struct packed {
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] height;
  } geom_t;

  typedef struct packed {
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
  } colors_t;

endpackage

/* rtl/glyph_bitmap_color_expand_unit.sv */
// Glyph bitmap color expansion unit: 1bpp glyph bytes in, RGB565 pixels out.
//
// Bitmap bytes are pushed row by row, each row padded to whole bytes, MSB
// leftmost. Each byte gives one word per pixel inside the glyph width (one to
// eight), carrying the foreground color for a set bit and the background
// color for a clear bit, plus row_end, glyph_end and last (final pixel of that
// byte). Padding bits are dropped. After the last row the position wraps to
// the next glyph. Rate: the single output shifter emits one pixel per cycle
// while the result register is free or popped, so a byte holds the shifter
// until all its pixels are out; a row's partial last byte has fewer pixels. The
// front end classifies a byte in the cycle it is accepted and a two-entry
// command queue lets it take bytes back to back until that queue fills.
// Bytes pass the queue, shifter and result register. Registers (APB, byte
// address 4*i): 0 fg_color, 1 back_color, 2 glyph_width, 3 glyph_height;
// widths and heights of zero act as one, above MAX_GLYPH_SIDE saturate.
// Writing width or height restarts the glyph at its top-left. Reconfigure
// only while idle.
module glyph_bitmap_color_expand_unit #(
  parameter int MAX_GLYPH_SIDE = gbce_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  // bitmap words in
  input  logic                         push,
  output logic                         full,
  input  logic [gbce_pkg::BYTE_W-1:0]  bitmap_byte,
  // pixel words out
  output logic                         empty,
  input  logic                         pop,
  output logic [gbce_pkg::COLOR_W-1:0] px_rgb,
  output logic                         row_end,
  output logic                         glyph_end,
  output logic                         last,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gbce_pkg::ADDR_W-1:0]  paddr,
  input  logic [gbce_pkg::DATA_W-1:0]  pwdata,
  output logic [gbce_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  gbce_pkg::colors_t  colors;
  gbce_pkg::geom_t    geom;
  gbce_pkg::reg_idx_t reg_idx;
  gbce_pkg::cmd_t     front_cmd, head_cmd;
  logic               cfg_wr, restart;
  logic               q_push, q_full, head_valid, head_pop;

  // Register file
  assign pready  = 1'b1;
  assign reg_idx = gbce_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  // geometry writes start a fresh glyph
  assign restart = cfg_wr && (reg_idx == gbce_pkg::REG_WIDTH ||
                              reg_idx == gbce_pkg::REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      colors.fg   <= gbce_pkg::FG_RESET;
      colors.bg   <= gbce_pkg::BG_RESET;
      geom.width  <= gbce_pkg::WIDTH_RESET;
      geom.height <= gbce_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        gbce_pkg::REG_FG:     colors.fg   <= pwdata[gbce_pkg::COLOR_W-1:0];
        gbce_pkg::REG_BG:     colors.bg   <= pwdata[gbce_pkg::COLOR_W-1:0];
        gbce_pkg::REG_WIDTH:  geom.width  <= pwdata[gbce_pkg::SIDE_W-1:0];
        gbce_pkg::REG_HEIGHT: geom.height <= pwdata[gbce_pkg::SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      gbce_pkg::REG_FG:     prdata = gbce_pkg::DATA_W'(colors.fg);
      gbce_pkg::REG_BG:     prdata = gbce_pkg::DATA_W'(colors.bg);
      gbce_pkg::REG_WIDTH:  prdata = gbce_pkg::DATA_W'(geom.width);
      gbce_pkg::REG_HEIGHT: prdata = gbce_pkg::DATA_W'(geom.height);
      default:              prdata = '0;
    endcase
  end

  assign full = q_full;

  // Front end: position tracking and classification
  gbce_front #(
    .MAX_GLYPH_SIDE(MAX_GLYPH_SIDE)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .bitmap_byte (bitmap_byte),
    .q_full      (q_full),
    .geom        (geom),
    .restart     (restart),
    .q_push      (q_push),
    .cmd         (front_cmd)
  );

  // Decoupling queue
  gbce_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_cmd   (front_cmd),
    .rd_en    (head_pop),
    .rd_cmd   (head_cmd),
    .rd_valid (head_valid),
    .full     (q_full)
  );

  // Back end: pixel shifter and result register
  gbce_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head_cmd),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .colors     (colors),
    .pop        (pop),
    .empty      (empty),
    .px_rgb     (px_rgb),
    .row_end    (row_end),
    .glyph_end  (glyph_end),
    .last       (last)
  );

endmodule

/* rtl/gbce_front.sv */
// Front end: accepts bitmap bytes, tracks column/row and classifies each byte.
module gbce_front #(
  parameter int MAX_GLYPH_SIDE = gbce_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [gbce_pkg::BYTE_W-1:0] bitmap_byte,
  input  logic                        q_full,
  input  gbce_pkg::geom_t             geom,
  input  logic                        restart,
  output logic                        q_push,
  output gbce_pkg::cmd_t              cmd
);

  localparam int POS_W  = $clog2(MAX_GLYPH_SIDE);
  localparam int SIDE_W = gbce_pkg::SIDE_W;
  localparam logic [SIDE_W-1:0] MAX_SIDE = SIDE_W'(MAX_GLYPH_SIDE);
  localparam logic [SIDE_W-1:0] BYTE_PIX = SIDE_W'(gbce_pkg::BYTE_W);

  logic [POS_W-1:0]  column_pos, column_pos_next;
  logic [POS_W-1:0]  row_pos, row_pos_next;
  logic [POS_W-1:0]  col_eff, row_eff;
  logic [SIDE_W-1:0] w, h, rem, col_sum;
  logic              row_done, last_row;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (v == '0) r = SIDE_W'(1);
    else if (v > MAX_SIDE) r = MAX_SIDE;
    else r = v;
    return r;
  endfunction

  always_comb begin
    w        = clamp_side(geom.width);
    h        = clamp_side(geom.height);
    col_eff  = (SIDE_W'(column_pos) >= w) ? '0 : column_pos;
    row_eff  = (SIDE_W'(row_pos) >= h) ? '0 : row_pos;
    rem      = w - SIDE_W'(col_eff);
    row_done = (rem <= BYTE_PIX);
    last_row = (SIDE_W'(row_eff) == h - SIDE_W'(1));
    col_sum  = SIDE_W'(col_eff) + BYTE_PIX;

    q_push        = push && !q_full;
    cmd.byte_bits = bitmap_byte;
    cmd.cnt_m1    = row_done ? gbce_pkg::CNT_W'(rem - SIDE_W'(1))
                             : gbce_pkg::CNT_W'(gbce_pkg::BYTE_W - 1);
    cmd.row_done  = row_done;
    cmd.last_row  = last_row;

    if (row_done) begin
      column_pos_next = '0;
      row_pos_next    = last_row ? '0 : row_eff + POS_W'(1);
    end else begin
      column_pos_next = POS_W'(col_sum);
      row_pos_next    = row_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      column_pos <= '0;
      row_pos    <= '0;
    end else if (q_push) begin
      column_pos <= column_pos_next;
      row_pos    <= row_pos_next;
    end
  end

endmodule

/* rtl/gbce_queue.sv */
// Short command queue between front end and back end.
module gbce_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  gbce_pkg::cmd_t wr_cmd,
  input  logic           rd_en,
  output gbce_pkg::cmd_t rd_cmd,
  output logic           rd_valid,
  output logic           full
);

  localparam int DEPTH = gbce_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  gbce_pkg::cmd_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= bump(wr_ptr);
      if (do_rd) rd_ptr <= bump(rd_ptr);
      if (do_wr && !do_rd) count <= count + CNT_W'(1);
      else if (do_rd && !do_wr) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_cmd;
  end

endmodule

/* rtl/gbce_back.sv */
// Back end: shifts out one pixel per cycle into the result register while it is free or popped.
module gbce_back (
  input  logic                         clk,
  input  logic                         rst,
  input  gbce_pkg::cmd_t               head,
  input  logic                         head_valid,
  output logic                         head_pop,
  input  gbce_pkg::colors_t            colors,
  input  logic                         pop,
  output logic                         empty,
  output logic [gbce_pkg::COLOR_W-1:0] px_rgb,
  output logic                         row_end,
  output logic                         glyph_end,
  output logic                         last
);

  localparam int BW = gbce_pkg::BYTE_W;
  localparam int CW = gbce_pkg::CNT_W;

  logic          cur_valid, cur_row_done, cur_last_row;
  logic [BW-1:0] cur_bits;
  logic [CW-1:0] cur_left;
  logic          out_valid;
  logic          adv, finishing;

  always_comb begin
    adv       = cur_valid && (!out_valid || pop);
    finishing = adv && (cur_left == '0);
    head_pop  = head_valid && (!cur_valid || finishing);
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (head_pop) cur_valid <= 1'b1;
      else if (finishing) cur_valid <= 1'b0;
      if (adv) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      cur_bits     <= head.byte_bits;
      cur_left     <= head.cnt_m1;
      cur_row_done <= head.row_done;
      cur_last_row <= head.last_row;
    end else if (adv) begin
      cur_bits <= {cur_bits[BW-2:0], 1'b0};
      cur_left <= cur_left - CW'(1);
    end
    if (adv) begin
      px_rgb    <= cur_bits[BW-1] ? colors.fg : colors.bg;
      last      <= (cur_left == '0);
      row_end   <= (cur_left == '0) && cur_row_done;
      glyph_end <= (cur_left == '0) && cur_row_done && cur_last_row;
    end
  end

endmodule

/* rtl/gbce_checker.sv */
// Port-level checker for the glyph bitmap color expansion unit, with bind.
`include "glyph_bitmap_color_expand_unit_assert.svh"

module gbce_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         empty,
  input logic                         pop,
  input logic [gbce_pkg::COLOR_W-1:0] px_rgb,
  input logic                         row_end,
  input logic                         glyph_end,
  input logic                         last
);

  `GBCE_ASSERT_IMP(a_glyph_end_row_end, clk, rst, !empty && glyph_end, row_end, "glyph_end without row_end")
  `GBCE_ASSERT_IMP(a_row_end_last, clk, rst, !empty && row_end, last, "row_end without last")
  `GBCE_ASSERT_NXT(a_reset_empty, clk, 1'b0, rst, empty, "output not empty after reset")
  `GBCE_ASSERT_NXT(a_stall_hold, clk, rst, !empty && !pop, !empty && $stable(px_rgb) && $stable(last), "stalled word changed")

endmodule

bind glyph_bitmap_color_expand_unit gbce_checker u_gbce_checker (
  .clk       (clk),
  .rst       (rst),
  .empty     (empty),
  .pop       (pop),
  .px_rgb    (px_rgb),
  .row_end   (row_end),
  .glyph_end (glyph_end),
  .last      (last)
);
